>>> hw/rtl/tlca_pkg.sv
// shared types, constants and state codes for the lca binary lifting unit
package tlca_pkg;

	localparam int MaxNodesDef   = 1024;
	localparam int LiftLevelsDef = 10;
	localparam int NodeW = 10;
	localparam int DistW = 48;
	localparam int CntW  = 11;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_BUILD = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_ANSWER = 2'd1;
	localparam logic [1:0] ST_NOBLD  = 2'd2;
	localparam logic [1:0] ST_NOANC  = 2'd3;

	typedef struct packed {
		logic [1:0]       func;
		logic [NodeW-1:0] first_node;
		logic [NodeW-1:0] second_node;
		logic [NodeW-1:0] parent_node;
		logic             has_parent;
		logic [NodeW-1:0] node_depth_in;
		logic [DistW-1:0] root_distance_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [NodeW-1:0] ancestor_node;
		logic [DistW-1:0] path_distance;
	} out_item_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LOAD,
		S_B_RD0, S_B_WT0, S_B_RD1, S_B_WT1, S_B_WR,
		S_Q_RD, S_Q_WT, S_Q_CMP,
		S_Q_LRD, S_Q_LWT,
		S_Q_JRD, S_Q_JWT,
		S_Q_PRD, S_Q_PWT,
		S_Q_DRD, S_Q_DWT, S_Q_D2, S_Q_D3,
		S_OUT
	} state_t;

endpackage

>>> hw/rtl/tlca_ram.sv
// generic single write port, two read port ram with registered read
module tlca_ram #(
	parameter int Width = 8,
	parameter int Depth = 16,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr_a,
	output logic [Width-1:0] rdata_a,
	input  logic [AddrW-1:0] raddr_b,
	output logic [Width-1:0] rdata_b
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> hw/rtl/tree_lca_binary_lifting_unit.sv
// top level: lowest common ancestor unit with binary lifting table
//
// channel  | signals                       | transfer when
// ---------+-------------------------------+-----------------------------
// input    | in_valid, in_ready, in_item   | in_valid && in_ready
// output   | out_valid, out_ready, out_item| out_valid && out_ready
// config   | cfg_we, cfg_wdata             | cfg_we high at a clock edge
//
// one item at a time; in_ready is low from input transfer until the result is taken
// load: S_LOAD writes the node, then out_valid rises as the unit enters S_OUT
// query: a read and a wait state per lift step, up to two states per depth bit,
// two per joint level
// build: LIFT_LEVELS-1 levels of min(node_count, MAX_NODES) entries, two dependent table
// reads per entry; reset clears control state only, rams hold junk until loaded
// a stalled output holds the result; no new input is taken meanwhile
module tree_lca_binary_lifting_unit
	import tlca_pkg::*;
#(
	parameter int MAX_NODES   = MaxNodesDef,
	parameter int LIFT_LEVELS = LiftLevelsDef
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_item_t        in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output out_item_t       out_item,
	input  logic            cfg_we,
	input  logic [CntW-1:0] cfg_wdata
);

	localparam int NIdxW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int LvlW  = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
	localparam int TDep  = MAX_NODES * LIFT_LEVELS;
	localparam int TAW   = $clog2(TDep);
	localparam int EntW  = NIdxW + 1;
	localparam int NcW   = NIdxW + 1;
	localparam logic [NcW-1:0] NodesMax = NcW'(MAX_NODES);
	localparam logic [DistW:0] DistMaxX = {1'b0, {DistW{1'b1}}};

	state_t state_q, state_n;

	// control registers
	logic [CntW-1:0]  node_count_q;
	logic             built_q;
	in_item_t         item_q;
	logic [NIdxW-1:0] x_q, y_q, i_q, lca_q;
	logic [LvlW-1:0]  lvl_q;
	logic [NodeW-1:0] diff_q;
	logic [EntW-1:0]  up_q;
	logic [DistW:0]   sum_q;
	logic [DistW+1:0] twice_q;
	out_item_t        res_q;
	logic             out_valid_q;
	logic [1:0]       st_r;

	// ram ports
	logic            t_we;
	logic [TAW-1:0]  t_wa, t_ra, t_rb;
	logic [EntW-1:0] t_wd, t_da, t_db;
	logic            n_we;
	logic [NIdxW-1:0] n_wa, n_ra, n_rb;
	logic [NodeW-1:0] d_da, d_db;
	logic [DistW-1:0] r_da, r_db;

	tlca_ram #(.Width(EntW), .Depth(TDep)) u_tab (
		.clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd),
		.raddr_a(t_ra), .rdata_a(t_da), .raddr_b(t_rb), .rdata_b(t_db)
	);
	tlca_ram #(.Width(NodeW), .Depth(MAX_NODES)) u_dep (
		.clk(clk), .we(n_we), .waddr(n_wa), .wdata(item_q.node_depth_in),
		.raddr_a(n_ra), .rdata_a(d_da), .raddr_b(n_rb), .rdata_b(d_db)
	);
	tlca_ram #(.Width(DistW), .Depth(MAX_NODES)) u_dst (
		.clk(clk), .we(n_we), .waddr(n_wa), .wdata(item_q.root_distance_in),
		.raddr_a(n_ra), .rdata_a(r_da), .raddr_b(n_rb), .rdata_b(r_db)
	);

	function automatic logic [TAW-1:0] taddr(input logic [NIdxW-1:0] n,
		input logic [LvlW-1:0] l);
		logic [TAW+LvlW:0] a;
		a = (TAW+LvlW+1)'(n) * (TAW+LvlW+1)'(LIFT_LEVELS) + (TAW+LvlW+1)'(l);
		return a[TAW-1:0];
	endfunction

	// build covers min(node_count, MAX_NODES) nodes
	logic [NcW-1:0] bcount;
	always_comb begin
		if (int'(node_count_q) > MAX_NODES)
			bcount = NodesMax;
		else
			bcount = NcW'(node_count_q);
	end

	logic [NIdxW-1:0] in_a, in_b;
	assign in_a = NIdxW'(item_q.first_node);
	assign in_b = NIdxW'(item_q.second_node);
	logic lvl_last, i_last;
	assign lvl_last = (lvl_q == LvlW'(LIFT_LEVELS - 1));
	assign i_last   = ((NcW'(i_q) + NcW'(1)) >= bcount);

	logic ent_ok;
	assign ent_ok = (t_da != '0) && (t_db != '0) && (t_da != t_db);

	// depth difference of the query pair, deeper minus shallower
	logic [NodeW-1:0] dnew;
	assign dnew = (d_da < d_db) ? NodeW'(d_db - d_da) : NodeW'(d_da - d_db);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				unique case (in_item.func)
					FUNC_LOAD:  state_n = S_LOAD;
					FUNC_BUILD: state_n = S_B_RD0;
					FUNC_QUERY: state_n = S_Q_RD;
					default:    state_n = S_OUT;
				endcase
			end
			S_LOAD:  state_n = S_OUT;
			S_B_RD0: state_n = (LIFT_LEVELS < 2 || bcount == '0) ? S_OUT : S_B_WT0;
			S_B_WT0: state_n = S_B_RD1;
			S_B_RD1: state_n = S_B_WT1;
			S_B_WT1: state_n = S_B_WR;
			S_B_WR:  state_n = (i_last && lvl_last) ? S_OUT : S_B_RD0;
			S_Q_RD:  state_n = built_q ? S_Q_WT : S_OUT;
			S_Q_WT:  state_n = S_Q_CMP;
			S_Q_CMP: state_n = S_Q_LRD;
			S_Q_LRD: state_n = S_Q_LWT;
			S_Q_LWT: state_n = S_Q_LRD;
			S_Q_JRD: state_n = S_Q_JWT;
			S_Q_JWT: state_n = S_Q_JRD;
			S_Q_PRD: state_n = S_Q_PWT;
			S_Q_PWT: state_n = S_Q_DRD;
			S_Q_DRD: state_n = S_Q_DWT;
			S_Q_DWT: state_n = S_Q_D2;
			S_Q_D2:  state_n = S_Q_D3;
			S_Q_D3:  state_n = S_OUT;
			S_OUT:   state_n = S_OUT;
			default: state_n = S_IDLE;
		endcase
		// data dependent exits
		unique case (state_q)
			S_Q_CMP: if ((dnew >> LIFT_LEVELS) != '0) state_n = S_OUT;
			S_Q_LRD: begin
				if (diff_q == '0) state_n = (x_q == y_q) ? S_Q_DRD : S_Q_JRD;
				else if (!diff_q[0]) state_n = S_Q_LRD;
			end
			S_Q_LWT: if (t_da == '0) state_n = S_OUT;
			S_Q_JWT: if (lvl_q == '0) state_n = S_Q_PRD;
			S_Q_PWT: if (t_da == '0) state_n = S_OUT;
			S_OUT:   if (out_ready) state_n = S_IDLE;
			default: ;
		endcase
	end

	// outputs to rams
	always_comb begin
		t_we = 1'b0;
		t_wa = taddr(i_q, lvl_q);
		t_wd = (up_q == '0) ? '0 : t_da;
		t_ra = taddr(x_q, lvl_q);
		t_rb = taddr(y_q, lvl_q);
		n_we = 1'b0;
		n_wa = in_a;
		n_ra = in_a;
		n_rb = in_b;
		unique case (state_q)
			S_LOAD: begin
				n_we = 1'b1;
				t_we = 1'b1;
				t_wa = taddr(in_a, '0);
				t_wd = item_q.has_parent ?
					EntW'(NIdxW'(item_q.parent_node)) + EntW'(1) : '0;
			end
			S_B_WT0, S_B_RD0: t_ra = taddr(i_q, LvlW'(lvl_q - LvlW'(1)));
			S_B_RD1, S_B_WT1: t_ra = taddr(NIdxW'(up_q - EntW'(1)),
				LvlW'(lvl_q - LvlW'(1)));
			S_B_WR: t_we = 1'b1;
			S_Q_PRD, S_Q_PWT: t_ra = taddr(x_q, '0);
			S_Q_DRD, S_Q_DWT: n_rb = lca_q;
			default: ;
		endcase
	end

	assign st_r = (state_q == S_Q_RD && !built_q) ? ST_NOBLD : ST_NOANC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_count_q <= CntW'(1024);
			built_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) node_count_q <= cfg_wdata;
			if (cfg_we || state_q == S_LOAD)
				built_q <= 1'b0;
			else if ((state_q == S_B_RD0 || state_q == S_B_WR) && state_n == S_OUT)
				built_q <= 1'b1;
			if (state_q != S_OUT && state_n == S_OUT) out_valid_q <= 1'b1;
			if (state_q == S_OUT && out_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				item_q <= in_item;
				res_q  <= '0;
				lvl_q  <= LvlW'(1);
				i_q    <= '0;
			end
			S_B_WT0: up_q <= t_da;
			S_B_WR: begin
				if (i_last) begin
					i_q   <= '0;
					lvl_q <= LvlW'(lvl_q + LvlW'(1));
				end else begin
					i_q <= NIdxW'(i_q + NIdxW'(1));
				end
			end
			S_Q_RD: if (!built_q) res_q.status <= st_r;
			S_Q_WT: ;
			S_Q_CMP: begin
				sum_q <= (DistW+1)'(r_da) + (DistW+1)'(r_db);
				lvl_q <= '0;
				diff_q <= dnew;
				if (d_da < d_db) begin
					x_q <= in_b; y_q <= in_a;
				end else begin
					x_q <= in_a; y_q <= in_b;
				end
				if ((dnew >> LIFT_LEVELS) != '0) res_q.status <= ST_NOANC;
			end
			S_Q_LRD: begin
				if (diff_q == '0) lvl_q <= LvlW'(LIFT_LEVELS - 1);
				else if (!diff_q[0]) begin
					diff_q <= diff_q >> 1;
					lvl_q  <= LvlW'(lvl_q + LvlW'(1));
				end
				if (diff_q == '0 && x_q == y_q) lca_q <= x_q;
			end
			S_Q_LWT: begin
				if (t_da == '0) res_q.status <= ST_NOANC;
				x_q    <= NIdxW'(t_da - EntW'(1));
				diff_q <= diff_q >> 1;
				lvl_q  <= LvlW'(lvl_q + LvlW'(1));
			end
			S_Q_JWT: begin
				if (ent_ok) begin
					x_q <= NIdxW'(t_da - EntW'(1));
					y_q <= NIdxW'(t_db - EntW'(1));
				end
				lvl_q <= LvlW'(lvl_q - LvlW'(1));
			end
			S_Q_PWT: begin
				if (t_da == '0) res_q.status <= ST_NOANC;
				lca_q <= NIdxW'(t_da - EntW'(1));
			end
			S_Q_DWT: twice_q <= {1'b0, r_db, 1'b0};
			S_Q_D2: begin
				if ((DistW+2)'(sum_q) < twice_q) sum_q <= '0;
				else sum_q <= (DistW+1)'((DistW+2)'(sum_q) - twice_q);
			end
			S_Q_D3: begin
				res_q.status        <= ST_ANSWER;
				res_q.ancestor_node <= NodeW'(lca_q);
				res_q.path_distance <= (sum_q > DistMaxX) ? {DistW{1'b1}}
					: sum_q[DistW-1:0];
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = res_q;

endmodule

>>> tb/sv/tb.sv
// testbench for the binary lifting lowest common ancestor unit
`timescale 1ns / 1ps

module tb;
	import tlca_pkg::*;

	localparam int NODES  = 1024;
	localparam int LEVELS = 10;
	localparam int LIMIT  = 200000;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [DistW-1:0] DIST_SAT = {DistW{1'b1}};

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	in_item_t        in_item;
	logic            out_valid;
	logic            out_ready;
	out_item_t       out_item;
	logic            cfg_we;
	logic [CntW-1:0] cfg_wdata;

	tree_lca_binary_lifting_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shadow copy of the tree state: lifting table holds node+1, zero for none
	logic [CntW-1:0]  lift_tbl [NODES][LEVELS];
	logic [NodeW-1:0] depth_mem [NODES];
	logic [DistW-1:0] dist_mem [NODES];
	logic             tbl_built;
	logic [CntW-1:0]  node_cnt;

	// tree under construction for the current phase
	logic [NodeW-1:0] tr_par [NODES];
	logic             tr_has [NODES];
	logic [NodeW-1:0] tr_dep [NODES];
	logic [DistW-1:0] tr_dist [NODES];

	out_item_t answers_due [$];
	int        mismatches;
	int        idle_cycles;
	bit        quiet;
	int        ready_hold;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------- predictor ----------------

	function automatic void shadow_build();
		int cnt;
		logic [CntW-1:0] up;
		cnt = (node_cnt > NODES) ? NODES : node_cnt;
		for (int j = 1; j < LEVELS; j++) begin
			for (int i = 0; i < cnt; i++) begin
				up = lift_tbl[i][j-1];
				lift_tbl[i][j] = (up != 0) ? lift_tbl[up-1][j-1] : '0;
			end
		end
		tbl_built = 1'b1;
	endfunction

	function automatic out_item_t lca_answer(logic [NodeW-1:0] a, logic [NodeW-1:0] b);
		out_item_t r;
		logic [NodeW-1:0] x, y, d, lca;
		logic [CntW-1:0]  e, ex, ey;
		logic [DistW+1:0] s, t;
		r = '0;
		if (!tbl_built) begin
			r.status = ST_NOBLD;
			return r;
		end
		x = a;
		y = b;
		if (depth_mem[x] < depth_mem[y]) begin
			x = b;
			y = a;
		end
		d = depth_mem[x] - depth_mem[y];
		// lift the deeper node by the depth difference
		for (int i = 0; i < LEVELS; i++) begin
			if (d[i]) begin
				e = lift_tbl[x][i];
				if (e == 0) begin
					r.status = ST_NOANC;
					return r;
				end
				x = NodeW'(e - CntW'(1));
			end
		end
		if (x == y) begin
			lca = x;
		end else begin
			// joint lift, top level down, jumping only where both exist and differ
			for (int i = LEVELS - 1; i >= 0; i--) begin
				ex = lift_tbl[x][i];
				ey = lift_tbl[y][i];
				if (ex != 0 && ey != 0 && ex != ey) begin
					x = NodeW'(ex - CntW'(1));
					y = NodeW'(ey - CntW'(1));
				end
			end
			e = lift_tbl[x][0];
			if (e == 0) begin
				r.status = ST_NOANC;
				return r;
			end
			lca = NodeW'(e - CntW'(1));
		end
		s = (DistW+2)'(dist_mem[a]) + (DistW+2)'(dist_mem[b]);
		t = {1'b0, dist_mem[lca], 1'b0};
		s = (t > s) ? '0 : s - t;
		r.status        = ST_ANSWER;
		r.ancestor_node = lca;
		r.path_distance = (s > DIST_SAT) ? DIST_SAT : s[DistW-1:0];
		return r;
	endfunction

	function automatic out_item_t apply_item(in_item_t it);
		out_item_t r;
		r = '0;
		case (it.func)
			FUNC_LOAD: begin
				lift_tbl[it.first_node][0] = it.has_parent ?
					CntW'(it.parent_node) + CntW'(1) : '0;
				depth_mem[it.first_node] = it.node_depth_in;
				dist_mem[it.first_node]  = it.root_distance_in;
				tbl_built = 1'b0;
			end
			FUNC_BUILD: shadow_build();
			FUNC_QUERY: r = lca_answer(it.first_node, it.second_node);
			default: ;
		endcase
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 13)
			return 0;
		if (r < 19)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	function automatic logic [DistW-1:0] rand_dist();
		return DistW'({$urandom, $urandom});
	endfunction

	task automatic send_item(in_item_t it);
		int gap;
		in_item  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		answers_due = {answers_due, apply_item(it)};
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_op(logic [1:0] f, logic [NodeW-1:0] a, logic [NodeW-1:0] b);
		in_item_t it;
		it = '0;
		it.func        = f;
		it.first_node  = a;
		it.second_node = b;
		// fields the op ignores still get random content
		it.parent_node      = NodeW'($urandom);
		it.has_parent       = 1'($urandom);
		it.node_depth_in    = NodeW'($urandom);
		it.root_distance_in = rand_dist();
		send_item(it);
	endtask

	task automatic send_load(logic [NodeW-1:0] n, logic [NodeW-1:0] p, logic hp,
			logic [NodeW-1:0] dep, logic [DistW-1:0] rdist);
		in_item_t it;
		it.func             = FUNC_LOAD;
		it.first_node       = n;
		it.second_node      = NodeW'($urandom);
		it.parent_node      = p;
		it.has_parent       = hp;
		it.node_depth_in    = dep;
		it.root_distance_in = rdist;
		send_item(it);
	endtask

	// drain all results, let the unit settle, then write the node count
	task automatic write_count(logic [CntW-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		node_cnt  = v;
		tbl_built = 1'b0;
	endtask

	// random forest over nodes 0..n-1, parent always below child so every
	// ancestor of a covered node is itself covered by the build
	task automatic make_tree(int n, int chain_pct);
		int p;
		for (int i = 0; i < n; i++) begin
			tr_has[i] = (i != 0) && ($urandom_range(0, 99) >= 6);
			if (!tr_has[i]) begin
				tr_par[i]  = NodeW'($urandom);
				tr_dep[i]  = '0;
				tr_dist[i] = ($urandom_range(0, 3) == 0) ? rand_dist() : '0;
			end else begin
				p = ($urandom_range(0, 99) < chain_pct) ? i - 1 : $urandom_range(0, i - 1);
				tr_par[i]  = NodeW'(p);
				tr_dep[i]  = tr_dep[p] + NodeW'(1);
				case ($urandom_range(0, 9))
					0: tr_dist[i] = rand_dist();
					1: tr_dist[i] = tr_dist[p] + (rand_dist() >> 1);
					default: tr_dist[i] = tr_dist[p] + DistW'($urandom_range(0, 1000));
				endcase
			end
			// now and then a depth that disagrees with the parent links
			if ($urandom_range(0, 29) == 0)
				tr_dep[i] = NodeW'($urandom);
		end
	endtask

	task automatic load_tree(int n);
		int order [];
		int k;
		order = new[n];
		for (int i = 0; i < n; i++)
			order[i] = i;
		order.shuffle();
		for (int i = 0; i < n; i++) begin
			k = order[i];
			send_load(NodeW'(k), tr_par[k], tr_has[k], tr_dep[k], tr_dist[k]);
		end
	endtask

	task automatic query_burst(int lim, int cnt);
		logic [NodeW-1:0] a, b;
		for (int i = 0; i < cnt; i++) begin
			a = NodeW'($urandom_range(0, lim - 1));
			case ($urandom_range(0, 5))
				0: b = a;
				1: b = tr_has[a] ? tr_par[a] : a;
				default: b = NodeW'($urandom_range(0, lim - 1));
			endcase
			send_op(FUNC_QUERY, a, b);
		end
	endtask

	// ---------------- tests ----------------

	task automatic test_unbuilt();
		send_op(FUNC_QUERY, 10'd0, 10'd1023);
		send_op(FUNC_UNUSED, 10'd1023, 10'd0);
		send_op(FUNC_QUERY, 10'd1023, 10'd1023);
	endtask

	task automatic test_small_tree();
		write_count(11'd8);
		send_load(0, 10'd1023, 1'b0, 0, '0);
		send_load(1, 0, 1'b1, 1, 48'd5);
		send_load(2, 0, 1'b1, 1, 48'd7);
		send_load(3, 1, 1'b1, 2, DIST_SAT);
		send_load(4, 2, 1'b1, 2, DIST_SAT);
		send_load(5, 10'd1023, 1'b0, 0, 48'd3);
		send_load(6, 5, 1'b1, 1, 48'd1);
		send_load(7, 3, 1'b1, 10'd1023, '0);
		send_op(FUNC_QUERY, 3, 4);
		send_op(FUNC_BUILD, 0, 0);
		send_op(FUNC_QUERY, 3, 4);   // ancestor at root, sum saturates
		send_op(FUNC_QUERY, 1, 3);
		send_op(FUNC_QUERY, 3, 1);
		send_op(FUNC_QUERY, 0, 0);
		send_op(FUNC_QUERY, 1, 2);
		send_op(FUNC_QUERY, 6, 0);   // different roots
		send_op(FUNC_QUERY, 7, 0);   // claimed depth walks off the root
		send_op(FUNC_QUERY, 5, 6);   // child closer to root than its root: clamps
		send_op(FUNC_UNUSED, 0, 0);
	endtask

	task automatic test_count_extremes();
		write_count(11'd0);
		send_op(FUNC_BUILD, 0, 0);
		send_op(FUNC_QUERY, 0, 0);   // no table reads needed
		write_count(11'd1);
		send_op(FUNC_BUILD, 0, 0);
		send_op(FUNC_QUERY, 0, 0);
	endtask

	// every node in use, deep chains reach all lift levels
	task automatic test_full_range();
		make_tree(NODES, 90);
		write_count(11'd2047);
		load_tree(NODES);
		send_op(FUNC_BUILD, 0, 0);
		query_burst(NODES, 60);
		send_op(FUNC_QUERY, 10'd1023, 10'd0);
	endtask

	task automatic test_random_trees();
		int n, cnt, lim;
		for (int round = 0; round < 5; round++) begin
			quiet = (round % 7 == 3);
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(2, 24);
			cnt = ($urandom_range(0, 2) == 0) ? $urandom_range(1, n) : n;
			make_tree(n, $urandom_range(0, 100));
			write_count(CntW'(cnt));
			load_tree(n);
			if ($urandom_range(0, 3) == 0)
				send_op(FUNC_QUERY, 0, 0);
			send_op(FUNC_BUILD, 0, 0);
			lim = cnt;
			query_burst(lim, $urandom_range(5, 25));
			if ($urandom_range(0, 2) == 0) begin
				// change one node, stale until rebuilt
				send_load(NodeW'(n - 1), tr_par[n - 1], tr_has[n - 1], tr_dep[n - 1],
					rand_dist());
				send_op(FUNC_QUERY, 0, 0);
				if ($urandom_range(0, 1) == 0)
					send_op(FUNC_UNUSED, NodeW'($urandom), NodeW'($urandom));
				send_op(FUNC_BUILD, 0, 0);
				query_burst(lim, $urandom_range(2, 8));
			end
		end
		quiet = 1'b0;
	endtask

	// ---------------- result checking ----------------

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", out_item);
			end else begin
				want = answers_due.pop_front();
				if (out_item.status !== want.status || out_item.ancestor_node !== want.ancestor_node
						|| out_item.path_distance !== want.path_distance) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected st=%0d anc=%0d dist=%0h, got st=%0d anc=%0d dist=%0h",
							want.status, want.ancestor_node, want.path_distance,
							out_item.status, out_item.ancestor_node, out_item.path_distance);
				end
			end
		end
		// receiver stalls: mostly short, a few long, none while quiet
		if (ready_hold > 0) begin
			out_ready  <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else begin
			out_ready <= 1'b1;
			if (!quiet && $urandom_range(0, 5) == 0)
				ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
					: $urandom_range(1, 3);
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_item     = '0;
		out_ready   = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		mismatches  = 0;
		idle_cycles = 0;
		ready_hold  = 0;
		quiet       = 1'b0;
		tbl_built   = 1'b0;
		node_cnt    = 11'd1024;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unbuilt();
		test_small_tree();
		test_count_extremes();
		test_full_range();
		test_random_trees();

		in_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && answers_due.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/tlca_pkg.sv
hw/rtl/tlca_ram.sv
hw/rtl/tree_lca_binary_lifting_unit.sv
tb/sv/tb.sv
